// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication into the following cycle, outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Sizes, codes and entry types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int PRIO_BITS  = 16;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [PRIO_BITS-1:0]  prio_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // One stored entry of the chain.
  typedef struct packed {
    logic   valid;
    value_t value;
    prio_t  prio;
  } entry_t;

  // Command broadcast to every cell in the cycle a request is taken.
  typedef struct packed {
    logic   ins;
    logic   rem;
    prio_t  key;
    value_t value;
  } cell_cmd_t;

endpackage

// File: rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels carrying queue requests and their responses.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
  logic   valid;
  logic   ready;
  op_t    func;
  value_t value_in;
  prio_t  prio_in;

  modport source (output valid, func, value_in, prio_in, input ready);
  modport sink   (input valid, func, value_in, prio_in, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
  logic    valid;
  logic    ready;
  value_t  value_out;
  prio_t   prio_out;
  status_t status;
  count_t  occupancy;

  modport source (output valid, value_out, prio_out, status, occupancy, input ready);
  modport sink   (input valid, value_out, prio_out, status, occupancy, output ready);
endinterface

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compare, hold, shift or load.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head,
  input  cell_cmd_t cmd,
  input  entry_t    left,
  input  entry_t    right,
  input  logic      left_stay,
  output entry_t    cur,
  output logic      stay
);

  // The head keeps its entry on a tie; later slots keep only strictly higher.
  assign stay = cur.valid && (head ? (cur.prio >= cmd.key) : (cur.prio > cmd.key));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (cmd.ins && !stay) begin
      if (left_stay) begin
        cur <= '{valid: 1'b1, value: cmd.value, prio: cmd.key};
      end else begin
        cur <= left;
      end
    end else if (cmd.rem) begin
      cur <= right;
    end
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: func selects insert or remove, value_in and
//   prio_in give the entry to insert (ignored on remove). rsp returns one
//   response per request: the removed head's value and priority (zero
//   otherwise), a status code and the occupancy after the request.
//   Every cell compares its own priority with the new key in parallel and
//   then holds, takes the new entry, or shifts one place toward the tail;
//   a remove shifts the whole chain one place toward the head.
//   The response is registered: it appears in the cycle after acceptance.
//   Throughput: one request per cycle; a request is taken whenever the
//   response register is empty or being drained in the same cycle.
//   Stall: while rsp is held, the pending response stays put and req.ready
//   drops; no request is lost or taken twice.
//   Reset: rst (synchronous, active high) empties the queue and the
//   response register; the queue is usable in the next cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
  input logic clk,
  input logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  entry_t               cells [CAPACITY];
  logic  [CAPACITY-1:0] stays;
  logic  [CAPACITY-1:0] valids;
  count_t               count;
  count_t               count_next;
  cell_cmd_t            cmd;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 order_ok;
  logic                 count_ok;
  logic                 ins_full;

  // Take a request whenever the response slot is free or drains now.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == count_t'(CAPACITY));
  assign empty     = (count == '0);

  // Drop inserts into a full queue and removes from an empty one.
  assign cmd.ins   = accept && (req.func == OP_INSERT) && !full;
  assign cmd.rem   = accept && (req.func == OP_REMOVE) && !empty;
  assign cmd.key   = req.prio_in;
  assign cmd.value = req.value_in;

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + count_t'(1);
    end else if (cmd.rem) begin
      count_next = count - count_t'(1);
    end
  end

  // Chain of cells: slot 0 is the head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_s;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_s = 1'b1;
    end else begin : g_body
      assign left_e = cells[i-1];
      assign left_s = stays[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .head      (i == 0),
      .cmd       (cmd),
      .left      (left_e),
      .right     (right_e),
      .left_stay (left_s),
      .cur       (cells[i]),
      .stay      (stays[i])
    );

    assign valids[i] = cells[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.occupancy <= count_next;
      if (cmd.rem) begin
        rsp.status    <= ST_REMOVED;
        rsp.value_out <= cells[0].value;
        rsp.prio_out  <= cells[0].prio;
      end else begin
        rsp.value_out <= '0;
        rsp.prio_out  <= '0;
        if (req.func == OP_INSERT) begin
          rsp.status <= full ? ST_FULL : ST_INSERTED;
        end else begin
          rsp.status <= ST_EMPTY;
        end
      end
    end
  end

  // Neighboring valid entries never rise in priority toward the tail.
  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (cells[i+1].valid && (cells[i].prio < cells[i+1].prio)) begin
        order_ok = 1'b0;
      end
    end
  end

  assign count_ok = (count_t'($countones(valids)) == count) && (valids[0] || empty);
  assign ins_full = accept && (req.func == OP_INSERT) && full;

  `SPQ_ASSERT(a_count_range, count <= count_t'(CAPACITY), "occupancy exceeds capacity")
  `SPQ_ASSERT(a_valid_prefix, count_ok, "cell valid bits disagree with occupancy")
  `SPQ_ASSERT(a_sorted, order_ok, "chain lost descending priority order")
  `SPQ_ASSERT_NEXT(a_full_reject, ins_full, (rsp.status == ST_FULL) && full, "full insert taken")

endmodule

// File: tb/sorted_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker
// Watches the request and response channels, keeps its own copy of the queue
// and compares every response with the expected one, in order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker import spq_pkg::*; (
  input  logic clk,
  input  logic rst,
  spq_req_if   req,
  spq_rsp_if   rsp,
  output int   mismatch_count,
  output int   pending_count
);

  typedef struct {
    value_t  value;
    prio_t   prio;
    status_t status;
    count_t  occupancy;
  } queue_rsp_t;

  value_t     held_value [CAPACITY];
  prio_t      held_prio  [CAPACITY];
  int         held_count;
  queue_rsp_t due_rsp [$];

  // Apply one request to the shadow queue and return its response.
  function automatic queue_rsp_t serve_request(op_t op, value_t v, prio_t p);
    queue_rsp_t r;
    int         pos;
    r.value     = '0;
    r.prio      = '0;
    r.status    = ST_INSERTED;
    if (op == OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // new head only on strictly higher priority; ties land behind equals
        // of the head but ahead of equals further down
        if (held_count == 0 || p > held_prio[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < held_count && held_prio[pos] > p) pos++;
        end
        for (int i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = v;
        held_prio[pos]  = p;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_REMOVED;
        r.value  = held_value[0];
        r.prio   = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_prio[i-1]  = held_prio[i];
        end
        held_count--;
      end
    end
    r.occupancy = count_t'(held_count);
    return r;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    held_count     = 0;
  end

  always @(posedge clk) begin
    queue_rsp_t exp_rsp;
    logic       bad;
    if (rst) begin
      held_count = 0;
      due_rsp.delete();
    end else begin
      // compare first: a response never belongs to a request taken this edge
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (due_rsp.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected response: value %0d prio %0d status %0d occ %0d",
                     $realtime, rsp.value_out, rsp.prio_out, rsp.status, rsp.occupancy);
          mismatch_count++;
        end else begin
          exp_rsp = due_rsp.pop_front();
          bad = 1'b0;
          if (rsp.value_out !== exp_rsp.value)     bad = 1'b1;
          if (rsp.prio_out  !== exp_rsp.prio)      bad = 1'b1;
          if (rsp.status    !== exp_rsp.status)    bad = 1'b1;
          if (rsp.occupancy !== exp_rsp.occupancy) bad = 1'b1;
          if (bad) begin
            if (mismatch_count < 10)
              $display("[%0t] response mismatch: exp value %0d prio %0d status %0d occ %0d, got value %0d prio %0d status %0d occ %0d",
                       $realtime, exp_rsp.value, exp_rsp.prio, exp_rsp.status,
                       exp_rsp.occupancy, rsp.value_out, rsp.prio_out, rsp.status,
                       rsp.occupancy);
            mismatch_count++;
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        due_rsp.push_back(serve_request(req.func, req.value_in, req.prio_in));
    end
    pending_count = due_rsp.size();
  end

endmodule

// File: tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives insert and remove requests into the sorted priority queue: a short
// directed sequence (empty remove, extreme fields, tie ordering, draining),
// then random phases that alternately fill past capacity and drain past
// empty, with random idling on both channels in most phases.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb import spq_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int LONG_HOLD    = 40;

  logic clk;
  logic rst;
  int   cycle_count;
  int   mismatch_count;
  int   pending_count;

  // idling knobs, changed by the stimulus per phase
  int   send_idle_pct;
  int   recv_idle_pct;
  logic quiet;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_priority_queue_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the run must finish well inside this many cycles.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one request and hold it until the queue takes it; afterwards
  // possibly drop valid for a random burst.
  task automatic send_request(input op_t op, input value_t v, input prio_t p);
    int gap;
    @(negedge clk);
    req_ch.valid    = 1'b1;
    req_ch.func     = op;
    req_ch.value_in = v;
    req_ch.prio_in  = p;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (!quiet && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every response has come back.
  task automatic drain_queue_responses();
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (pending_count == 0);
  endtask

  // Half the time a small spread of priorities so ties are common; some extremes and
  // some fully random keys to toggle every bit.
  function automatic prio_t pick_prio();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return prio_t'($urandom_range(0, 6) - 3);
    if (sel < 70) begin
      case ($urandom_range(4))
        0:       return prio_t'(16'h7fff);
        1:       return prio_t'(16'h8000);
        2:       return prio_t'(16'hffff);
        3:       return prio_t'(16'h0001);
        default: return prio_t'(16'h0000);
      endcase
    end
    return prio_t'($urandom);
  endfunction

  function automatic value_t pick_value();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? value_t'(32'h7fff_ffff)
                                                         : value_t'(32'h8000_0000);
    return value_t'($urandom);
  endfunction

  // Response side: hold off for a long stretch first so the block backs up
  // while requests keep coming, then stall in random bursts.
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    repeat (LONG_HOLD) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(99) < recv_idle_pct) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
    end
  end

  initial begin
    int ins_pct;
    req_ch.valid    = 1'b0;
    req_ch.func     = OP_INSERT;
    req_ch.value_in = '0;
    req_ch.prio_in  = '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 20;
    quiet           = 1'b0;
    rst             = 1'b1;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: remove on empty with junk in the ignored fields.
    send_request(OP_REMOVE, value_t'(32'h7fff_ffff), prio_t'(16'h7fff));
    // Extreme values and priorities.
    send_request(OP_INSERT, value_t'(32'h8000_0000), prio_t'(16'h8000));
    send_request(OP_INSERT, value_t'(32'h7fff_ffff), prio_t'(16'h7fff));
    // Equal priorities behind the head: the newest goes ahead of earlier equals.
    send_request(OP_INSERT, value_t'(1), prio_t'(5));
    send_request(OP_INSERT, value_t'(2), prio_t'(5));
    send_request(OP_INSERT, value_t'(3), prio_t'(5));
    // Tie with the head goes right behind it, not in front.
    send_request(OP_INSERT, value_t'(4), prio_t'(16'h7fff));
    send_request(OP_INSERT, value_t'(5), prio_t'(6));
    send_request(OP_INSERT, value_t'(-1), prio_t'(-1));
    send_request(OP_INSERT, value_t'(0), prio_t'(0));
    // Drain all nine entries and one more to hit empty again.
    repeat (10) send_request(OP_REMOVE, pick_value(), pick_prio());

    // Sender pause: let every response arrive before the random part.
    drain_queue_responses();

    // Random: alternate fill-heavy and drain-heavy phases so both the full
    // reject and the empty remove come up often.
    for (int ph = 0; ph < PHASES; ph++) begin
      ins_pct       = (ph % 2 == 0) ? 80 : 25;
      send_idle_pct = (ph == 2) ? 0 : $urandom_range(10, 50);
      recv_idle_pct = (ph == 2) ? 0 : $urandom_range(10, 50);
      quiet         = (ph == PHASES - 1);
      if (ph == PHASES / 2) drain_queue_responses();
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(99) < ins_pct)
          send_request(OP_INSERT, pick_value(), pick_prio());
        else
          send_request(OP_REMOVE, pick_value(), pick_prio());
      end
    end

    // Wind down: nothing left to offer, wait for the last responses.
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (pending_count == 0);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
